// ===== design/cpr_pkg.sv =====
// Types, codes and helpers for the clock page replacement block.
package cpr_pkg;

  localparam int DEPTH        = 64;
  localparam int PAGE_ID_BITS = 20;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [PAGE_ID_BITS-1:0] page_t;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_VICTIM = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_VICTIM   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic  req_type;
    page_t page_id;
  } req_t;

  typedef struct packed {
    status_t status;
    page_t   victim_page;
  } rsp_t;

  typedef struct packed {
    logic  ref_bit;
    page_t page;
  } entry_t;

  // Circular add: a is a valid slot, b is at most DEPTH, so one subtract wraps.
  function automatic idx_t wrap_add(idx_t a, cnt_t b);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== design/clock_page_replacement.sv =====
// Clock (second-chance) page replacement over a circular page memory.
//
//  channel   | signals                  | handshake
//  ----------+--------------------------+----------------------------------
//  request   | req (req_type, page_id)  | taken at start & !busy
//  result    | rsp (status, victim_page)| one cycle, marked by done
//
// Insert, full reject and empty victim requests: the result shows in the cycle
// after the transaction is taken, busy stays low. A victim request with pages
// resident scans past k pages first (k at most the page count):
// each pass-over is one read-modify-write step of the page memory.
// Reset clears the hand, the count and the strobe; the page memory needs no
// clearing, since every resident entry is written before it is read.
// busy drops in the cycle the result is shown; the receiver never stalls.
module clock_page_replacement (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cpr_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output cpr_pkg::rsp_t rsp
);
  import cpr_pkg::*;

  state_t state, state_next;
  idx_t   oldest, oldest_next;
  cnt_t   count, count_next;
  logic   done_next;
  rsp_t   rsp_next;

  entry_t mem [DEPTH];
  entry_t rd_q;
  entry_t fwd_data;
  logic   fwd_hit;
  entry_t cur;

  logic   we;
  idx_t   wr_addr;
  entry_t wr_data;
  idx_t   rd_addr;

  // Bypass the memory when last cycle's write hit the address being read.
  assign cur  = fwd_hit ? fwd_data : rd_q;
  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && req.req_type == REQ_VICTIM && count != '0) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!cur.ref_bit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we          = 1'b0;
    wr_addr     = wrap_add(oldest, count);
    wr_data     = '{ref_bit: 1'b1, page: req.page_id};
    rd_addr     = oldest;
    oldest_next = oldest;
    count_next  = count;
    done_next   = 1'b0;
    rsp_next    = '{status: ST_INSERTED, victim_page: '0};
    case (state)
      S_IDLE: begin
        if (start) begin
          if (req.req_type == REQ_INSERT) begin
            done_next = 1'b1;
            if (count == CNT_W'(DEPTH)) begin
              rsp_next.status = ST_FULL;
            end else begin
              we         = 1'b1;
              count_next = count + CNT_W'(1);
            end
          end else if (count == '0) begin
            done_next       = 1'b1;
            rsp_next.status = ST_EMPTY;
          end
        end
      end
      S_SCAN: begin
        oldest_next = wrap_add(oldest, CNT_W'(1));
        if (!cur.ref_bit) begin
          done_next            = 1'b1;
          rsp_next.status      = ST_VICTIM;
          rsp_next.victim_page = cur.page;
          count_next           = count - CNT_W'(1);
        end else begin
          // second chance: move the page to the back with its bit cleared
          we      = 1'b1;
          wr_data = '{ref_bit: 1'b0, page: cur.page};
          rd_addr = oldest_next;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q     <= mem[rd_addr];
    fwd_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      oldest  <= '0;
      count   <= '0;
      done    <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      state   <= state_next;
      oldest  <= oldest_next;
      count   <= count_next;
      done    <= done_next;
      fwd_hit <= we && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("page count above capacity");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> count != '0)
    else $error("scan with no resident page");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy) || $past(state == S_SCAN))
    else $error("result without a transaction");

  a_victim_from_scan: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == ST_VICTIM |-> $past(state == S_SCAN) && !busy)
    else $error("victim result outside a scan");

  a_scan_one_result: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && state_next == S_SCAN |=> !done)
    else $error("result while still scanning");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for clock_page_replacement: random insert/victim traffic checked against a shadow model.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cpr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 450;
  localparam int SETTLE_CYCLES = DEPTH + 16;

  // Shadow of the page ring; predicts the outcome of each taken transaction.
  class victim_scoreboard;
    page_t   frames [DEPTH];
    bit      referenced [DEPTH];
    int      hand;
    int      resident;
    rsp_t    expected_outcomes [$];
    int      failures;

    function new();
      hand = 0;
      resident = 0;
      failures = 0;
      foreach (referenced[i]) referenced[i] = 1'b0;
    endfunction

    function rsp_t predict_outcome(req_t r);
      rsp_t o;
      int   back;
      o.status = ST_INSERTED;
      o.victim_page = '0;
      if (r.req_type == REQ_INSERT) begin
        if (resident == DEPTH) begin
          o.status = ST_FULL;
        end else begin
          back = (hand + resident) % DEPTH;
          frames[back] = r.page_id;
          referenced[back] = 1'b1;
          resident++;
        end
      end else if (resident == 0) begin
        o.status = ST_EMPTY;
      end else begin
        // second chance: clear the bit and rotate the page to the back
        while (referenced[hand]) begin
          back = (hand + resident) % DEPTH;
          frames[back] = frames[hand];
          referenced[back] = 1'b0;
          referenced[hand] = 1'b0;
          hand = (hand + 1) % DEPTH;
        end
        o.status = ST_VICTIM;
        o.victim_page = frames[hand];
        hand = (hand + 1) % DEPTH;
        resident--;
      end
      return o;
    endfunction

    function void note_request(req_t r);
      expected_outcomes.push_back(predict_outcome(r));
    endfunction

    function void check_outcome(rsp_t got);
      rsp_t want;
      if (expected_outcomes.size() == 0) begin
        $error("unexpected result: status %0d victim_page %h", got.status, got.victim_page);
        failures++;
        return;
      end
      want = expected_outcomes.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        failures++;
      end
      if (got.victim_page !== want.victim_page) begin
        $error("victim_page: expected %h, actual %h", want.victim_page, got.victim_page);
        failures++;
      end
    endfunction
  endclass

  logic  clk;
  logic  rst;
  logic  start;
  req_t  req;
  logic  busy;
  logic  done;
  rsp_t  rsp;

  victim_scoreboard sb;
  int    cycles;
  int    sent;
  int    fill_level;

  clock_page_replacement dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Note each transaction at the edge that takes it, check each strobed result.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (!rst) begin
      if (start && !busy) sb.note_request(req);
      if (done) sb.check_outcome(rsp);
    end
  end

  // Hold the request until the block takes it; start stays high for the next one.
  task automatic issue(input logic kind, input page_t id);
    req_t r;
    r.req_type = kind;
    r.page_id = id;
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    sent++;
    if (kind == REQ_INSERT) begin
      if (fill_level < DEPTH) fill_level++;
    end else if (fill_level > 0) begin
      fill_level--;
    end
  endtask

  // Random sender gaps, except for a steady stretch in the middle of the run.
  task automatic issue_paced(input logic kind, input page_t id);
    if (!(sent >= 200 && sent < 300) && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      @(posedge clk);
    end
    issue(kind, id);
  endtask

  function automatic page_t any_page();
    return page_t'($urandom());
  endfunction

  initial begin
    int mode;
    int n;
    int p;
    sb = new();
    sent = 0;
    fill_level = 0;
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty victim, id extremes, duplicates, full sweep, ignored id
    issue(REQ_VICTIM, '0);
    issue(REQ_INSERT, '0);
    issue(REQ_INSERT, '1);
    issue(REQ_INSERT, '1);
    issue(REQ_INSERT, 20'h5A5A5);
    issue(REQ_VICTIM, '0);
    issue(REQ_INSERT, 20'h12345);
    issue(REQ_VICTIM, 20'hAAAAA);
    issue(REQ_VICTIM, 20'h55555);
    issue(REQ_VICTIM, '1);
    issue(REQ_INSERT, 20'hAAAAA);
    issue(REQ_VICTIM, '0);
    issue(REQ_VICTIM, '0);
    issue(REQ_VICTIM, '0);

    // random: fill to full, drain to empty, or mixed runs with a random insert share
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 4);
      if (mode == 0) begin
        while (fill_level < DEPTH) issue_paced(REQ_INSERT, any_page());
        repeat ($urandom_range(1, 4)) issue_paced(REQ_INSERT, any_page());
      end else if (mode == 1) begin
        while (fill_level > 0) issue_paced(REQ_VICTIM, any_page());
        repeat ($urandom_range(1, 3)) issue_paced(REQ_VICTIM, any_page());
      end else begin
        n = $urandom_range(20, 40);
        p = $urandom_range(10, 90);
        repeat (n) begin
          if ($urandom_range(0, 99) < p) issue_paced(REQ_INSERT, any_page());
          else issue_paced(REQ_VICTIM, any_page());
        end
      end
    end
    start <= 1'b0;

    while (sb.expected_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.expected_outcomes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/cpr_pkg.sv
design/clock_page_replacement.sv
sim/tb_top.sv
